@@ sv/i2cm_pkg.sv @@
// Package: types, phase codes and command codes of the I2C master byte sequencer.
`default_nettype none

package i2cm_pkg;

	localparam int unsigned HOLD_W     = 10;
	localparam int unsigned POLL_W     = 8;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned BITCNT_W   = 4;
	localparam int unsigned CMD_W      = 3;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 10;

	localparam logic [HOLD_W-1:0]   HOLD_RESET    = 10'd5;
	localparam logic [POLL_W-1:0]   TIMEOUT_RESET = 8'd250;
	localparam logic [BITCNT_W-1:0] BYTE_BITS     = 4'd8;
	localparam logic [BYTE_W-1:0]   MSB_MASK      = 8'h80;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD_TICKS = 1'b0,
		CFG_ACK_POLLS  = 1'b1
	} cfg_idx_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_WACK  = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_ST0    = 5'd1,
		PH_ST1    = 5'd2,
		PH_ST2    = 5'd3,
		PH_ST3    = 5'd4,
		PH_SP0    = 5'd5,
		PH_SP1    = 5'd6,
		PH_SP2    = 5'd7,
		PH_SP3    = 5'd8,
		PH_WA0    = 5'd9,
		PH_WA1    = 5'd10,
		PH_POLL   = 5'd11,
		PH_WAEND  = 5'd12,
		PH_WRSDA  = 5'd13,
		PH_WRHI   = 5'd14,
		PH_WRLO   = 5'd15,
		PH_RDLO   = 5'd16,
		PH_RDHI   = 5'd17,
		PH_RDSMP  = 5'd18,
		PH_AKLO   = 5'd19,
		PH_AKSDA  = 5'd20,
		PH_AKHI   = 5'd21,
		PH_AKLO2  = 5'd22,
		PH_FINISH = 5'd23
	} phase_t;

	typedef struct packed {
		logic              cmd_valid;
		logic [CMD_W-1:0]  command;
		logic [BYTE_W-1:0] write_byte;
		logic              send_ack;
		logic              sda_in;
	} tick_t;

	typedef struct packed {
		logic              scl_level;
		logic              sda_level;
		logic              sda_drive;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_data;
		logic              ack_failed;
	} res_t;

endpackage

`default_nettype wire

@@ sv/i2cm_if.sv @@
// Interfaces: tick input channel and result output channel.
`default_nettype none

interface i2cm_tick_if import i2cm_pkg::*; ();
	logic  valid;
	logic  ready;
	tick_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_res_if import i2cm_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/i2c_master_byte_sequencer.sv @@
// Top level: I2C master byte sequencer, one tick per cycle unless the result stalls.
//
//  channel | direction | payload
//  --------+-----------+---------------------------------------------------------
//  tick    | in        | cmd_valid, command, write_byte, send_ack, sda_in
//  res     | out       | scl_level, sda_level, sda_drive, busy_res, done_res,
//          |           | read_data, ack_failed
//  cfg     | in        | cfg_we, cfg_index, cfg_wdata (hold_ticks, ack_timeout_polls)
//
// One tick transaction per clock unless the result stalls: each accepted tick
// updates the state and loads one result into the output register in the same edge.
// The output register is the only stage; tick.ready stays high while the result
// register is empty or being taken, so a stalled result holds off only new ticks.
// arst_n clears the phase, counters and pin latches (SCL, SDA, drive all high)
// and loads hold_ticks = 5, ack_timeout_polls = 250.
`default_nettype none

module i2c_master_byte_sequencer import i2cm_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	i2cm_tick_if.sink                  tick,
	i2cm_res_if.source                 res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Configuration registers.
	logic [HOLD_W-1:0] hold_ticks_q;
	logic [POLL_W-1:0] ack_polls_q;

	// Sequencer state.
	phase_t              phase_q, n_phase;
	logic [BITCNT_W-1:0] bit_cnt_q, n_bit_cnt;
	logic [BYTE_W-1:0]   shift_q, n_shift;
	logic [HOLD_W-1:0]   hold_cnt_q, n_hold_cnt;
	logic [POLL_W-1:0]   poll_cnt_q, n_poll_cnt;
	logic                scl_q, n_scl;
	logic                sda_q, n_sda;
	logic                drive_q, n_drive;
	logic                ack_flag_q, n_ack_flag;
	logic [BYTE_W-1:0]   rdata_q, n_rdata;
	logic                fail_q, n_fail;

	// Result register.
	logic res_valid_q;
	res_t res_q, n_res;

	logic   accept;
	logic   act;
	logic   done;
	phase_t nxt;

	// Accept a tick whenever the result slot is free or drains this cycle.
	assign tick.ready  = !res_valid_q || res.ready;
	assign accept      = tick.valid && tick.ready;
	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	always_comb begin
		n_phase    = phase_q;
		n_bit_cnt  = bit_cnt_q;
		n_shift    = shift_q;
		n_hold_cnt = hold_cnt_q;
		n_poll_cnt = poll_cnt_q;
		n_scl      = scl_q;
		n_sda      = sda_q;
		n_drive    = drive_q;
		n_ack_flag = ack_flag_q;
		n_rdata    = rdata_q;
		n_fail     = fail_q;
		act        = 1'b0;
		done       = 1'b0;
		nxt        = PH_FINISH;

		if (phase_q == PH_IDLE) begin
			// Take a command only while idle; unknown codes are dropped.
			if (tick.payload.cmd_valid && tick.payload.command <= CMD_READ) begin
				n_bit_cnt  = '0;
				n_poll_cnt = '0;
				n_hold_cnt = '0;
				act        = 1'b1;
				case (cmd_t'(tick.payload.command))
					CMD_START: n_phase = PH_ST0;
					CMD_STOP:  n_phase = PH_SP0;
					CMD_WRITE: begin
						n_phase = PH_WRSDA;
						n_shift = tick.payload.write_byte;
					end
					CMD_WACK: begin
						n_phase = PH_WA0;
						n_fail  = 1'b0;
					end
					default: begin
						n_phase    = PH_RDLO;
						n_shift    = '0;
						n_ack_flag = tick.payload.send_ack;
					end
				endcase
			end
		end else if (hold_cnt_q != '0) begin
			n_hold_cnt = hold_cnt_q - 1'b1;
		end else begin
			act = 1'b1;
		end

		if (act) begin
			case (n_phase)
				PH_ST0: begin
					n_drive = 1'b1;
					n_sda   = 1'b1;
					nxt     = PH_ST1;
				end
				PH_ST1: begin
					n_scl = 1'b1;
					nxt   = PH_ST2;
				end
				PH_ST2: begin
					n_sda = 1'b0;
					nxt   = PH_ST3;
				end
				PH_ST3: n_scl = 1'b0;
				PH_SP0: begin
					n_drive = 1'b1;
					n_scl   = 1'b0;
					nxt     = PH_SP1;
				end
				PH_SP1: begin
					n_sda = 1'b0;
					nxt   = PH_SP2;
				end
				PH_SP2: begin
					n_scl = 1'b1;
					nxt   = PH_SP3;
				end
				PH_SP3: n_sda = 1'b1;
				PH_WA0: begin
					n_drive = 1'b0;
					n_sda   = 1'b1;
					nxt     = PH_WA1;
				end
				PH_WA1: begin
					n_scl = 1'b1;
					nxt   = PH_POLL;
				end
				PH_POLL: begin
					// Low SDA is the acknowledge; too many high polls abort with a stop.
					if (!tick.payload.sda_in) begin
						nxt = PH_WAEND;
					end else if (n_poll_cnt >= ack_polls_q) begin
						n_fail = 1'b1;
						nxt    = PH_SP0;
					end else begin
						n_poll_cnt = n_poll_cnt + 1'b1;
						nxt        = PH_POLL;
					end
				end
				PH_WAEND: n_scl = 1'b0;
				PH_WRSDA: begin
					n_drive = 1'b1;
					n_sda   = |(n_shift & MSB_MASK);
					n_shift = {n_shift[BYTE_W-2:0], 1'b0};
					nxt     = PH_WRHI;
				end
				PH_WRHI: begin
					n_scl = 1'b1;
					nxt   = PH_WRLO;
				end
				PH_WRLO: begin
					n_scl     = 1'b0;
					n_bit_cnt = n_bit_cnt + 1'b1;
					nxt       = (n_bit_cnt >= BYTE_BITS) ? PH_FINISH : PH_WRSDA;
				end
				PH_RDLO: begin
					n_drive = 1'b0;
					n_scl   = 1'b0;
					nxt     = PH_RDHI;
				end
				PH_RDHI: begin
					n_scl = 1'b1;
					nxt   = PH_RDSMP;
				end
				PH_RDSMP: begin
					n_shift   = {n_shift[BYTE_W-2:0], tick.payload.sda_in};
					n_bit_cnt = n_bit_cnt + 1'b1;
					if (n_bit_cnt >= BYTE_BITS) begin
						n_rdata = n_shift;
						nxt     = PH_AKLO;
					end else begin
						nxt = PH_RDLO;
					end
				end
				PH_AKLO: begin
					n_scl = 1'b0;
					nxt   = PH_AKSDA;
				end
				PH_AKSDA: begin
					n_drive = 1'b1;
					n_sda   = !n_ack_flag;
					nxt     = PH_AKHI;
				end
				PH_AKHI: begin
					n_scl = 1'b1;
					nxt   = PH_AKLO2;
				end
				PH_AKLO2: n_scl = 1'b0;
				default: begin
					// Finish tick: no pin change, pulse done, drop back to idle.
					nxt  = PH_IDLE;
					done = 1'b1;
				end
			endcase
			n_phase = nxt;
			// Reload the hold count; a zero hold acts as one tick.
			if (nxt != PH_IDLE && hold_ticks_q != '0) begin
				n_hold_cnt = hold_ticks_q - 1'b1;
			end else begin
				n_hold_cnt = '0;
			end
		end

		n_res.scl_level  = n_scl;
		n_res.sda_level  = n_sda;
		n_res.sda_drive  = n_drive;
		n_res.busy_res   = (n_phase != PH_IDLE);
		n_res.done_res   = done;
		n_res.read_data  = n_rdata;
		n_res.ack_failed = n_fail;
	end

	// Configuration writes land at any time; out-of-range indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_RESET;
			ack_polls_q  <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HOLD_TICKS: hold_ticks_q <= cfg_wdata[HOLD_W-1:0];
				CFG_ACK_POLLS:  ack_polls_q  <= cfg_wdata[POLL_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the sequencer on every accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_cnt_q  <= '0;
			shift_q    <= '0;
			hold_cnt_q <= '0;
			poll_cnt_q <= '0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			drive_q    <= 1'b1;
			ack_flag_q <= 1'b0;
			rdata_q    <= '0;
			fail_q     <= 1'b0;
		end else if (accept) begin
			phase_q    <= n_phase;
			bit_cnt_q  <= n_bit_cnt;
			shift_q    <= n_shift;
			hold_cnt_q <= n_hold_cnt;
			poll_cnt_q <= n_poll_cnt;
			scl_q      <= n_scl;
			sda_q      <= n_sda;
			drive_q    <= n_drive;
			ack_flag_q <= n_ack_flag;
			rdata_q    <= n_rdata;
			fail_q     <= n_fail;
		end
	end

	// Hold the result until taken; load a fresh one with each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= n_res;
		end
	end

endmodule

`default_nettype wire

@@ tb/tb_i2c_master_byte_sequencer.sv @@
// Self-checking testbench: I2C master byte sequencer driven tick by tick against a local predictor.
`timescale 1ns / 1ps

module tb_i2c_master_byte_sequencer;
	import i2cm_pkg::*;

	// Allow the slowest legal run: a few thousand ticks, each waiting out the longest
	// sender gap and the longest result stall, then many times that over.
	localparam int unsigned CYCLE_LIMIT        = 1_000_000;
	localparam int unsigned DRAIN_CYCLES       = 32;
	localparam int unsigned RANDOM_PHASES      = 3;
	localparam int unsigned COMMANDS_PER_PHASE = 5;
	localparam logic [3:0]  BITS_PER_BYTE      = 4'd8;
	localparam logic [2:0]  CMD_CODE_MAX       = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	i2cm_tick_if tick_ch ();
	i2cm_res_if  res_ch ();

	i2c_master_byte_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Chance in percent that an item draws a random wait, per side.
	int unsigned gap_pct   = 20;
	int unsigned stall_pct = 20;
	int unsigned error_count   = 0;
	int unsigned command_count = 0;
	int unsigned cycle_count   = 0;

	// Pin levels and flags the sequencer should report, oldest first.
	res_t expected_levels [$];

	// Local copy of the sequencer state and its two registers.
	logic [HOLD_W-1:0]   hold_cfg   = 10'd5;
	logic [POLL_W-1:0]   polls_cfg  = 8'd250;
	phase_t              seq_phase  = PH_IDLE;
	logic [BITCNT_W-1:0] bit_cnt    = '0;
	logic [BYTE_W-1:0]   shift_byte = '0;
	logic [HOLD_W-1:0]   hold_cnt   = '0;
	logic [POLL_W-1:0]   poll_cnt   = '0;
	logic                scl_q      = 1'b1;
	logic                sda_q      = 1'b1;
	logic                drive_q    = 1'b1;
	logic                ack_drive  = 1'b0;
	logic [BYTE_W-1:0]   rd_data    = '0;
	logic                fail_flag  = 1'b0;

	// Advance the local sequencer by one tick and return the levels after it.
	function automatic res_t next_bus_levels(input tick_t t);
		res_t   r;
		phase_t nxt;
		logic   act;
		logic   done;
		act  = 1'b0;
		done = 1'b0;
		if (seq_phase == PH_IDLE) begin
			// Take a command only while idle and only with a legal code.
			if (t.cmd_valid && t.command <= CMD_READ) begin
				bit_cnt  = '0;
				poll_cnt = '0;
				hold_cnt = '0;
				case (cmd_t'(t.command))
					CMD_START: seq_phase = PH_ST0;
					CMD_STOP: seq_phase = PH_SP0;
					CMD_WRITE: begin
						seq_phase  = PH_WRSDA;
						shift_byte = t.write_byte;
					end
					CMD_WACK: begin
						seq_phase = PH_WA0;
						fail_flag = 1'b0;
					end
					default: begin
						seq_phase  = PH_RDLO;
						shift_byte = '0;
						ack_drive  = t.send_ack;
					end
				endcase
				act = 1'b1;
			end
		end else if (hold_cnt != '0) begin
			hold_cnt = hold_cnt - 1'b1;
		end else begin
			act = 1'b1;
		end

		if (act) begin
			nxt = PH_FINISH;
			case (seq_phase)
				PH_ST0: begin
					drive_q = 1'b1;
					sda_q   = 1'b1;
					nxt     = PH_ST1;
				end
				PH_ST1: begin
					scl_q = 1'b1;
					nxt   = PH_ST2;
				end
				PH_ST2: begin
					sda_q = 1'b0;
					nxt   = PH_ST3;
				end
				PH_ST3: scl_q = 1'b0;
				PH_SP0: begin
					drive_q = 1'b1;
					scl_q   = 1'b0;
					nxt     = PH_SP1;
				end
				PH_SP1: begin
					sda_q = 1'b0;
					nxt   = PH_SP2;
				end
				PH_SP2: begin
					scl_q = 1'b1;
					nxt   = PH_SP3;
				end
				PH_SP3: sda_q = 1'b1;
				PH_WA0: begin
					drive_q = 1'b0;
					sda_q   = 1'b1;
					nxt     = PH_WA1;
				end
				PH_WA1: begin
					scl_q = 1'b1;
					nxt   = PH_POLL;
				end
				PH_POLL: begin
					// Low SDA is the acknowledge; too many high polls fall into stop.
					if (!t.sda_in) begin
						nxt = PH_WAEND;
					end else if (poll_cnt >= polls_cfg) begin
						fail_flag = 1'b1;
						nxt       = PH_SP0;
					end else begin
						poll_cnt = poll_cnt + 1'b1;
						nxt      = PH_POLL;
					end
				end
				PH_WAEND: scl_q = 1'b0;
				PH_WRSDA: begin
					drive_q    = 1'b1;
					sda_q      = shift_byte[BYTE_W-1];
					shift_byte = shift_byte << 1;
					nxt        = PH_WRHI;
				end
				PH_WRHI: begin
					scl_q = 1'b1;
					nxt   = PH_WRLO;
				end
				PH_WRLO: begin
					scl_q   = 1'b0;
					bit_cnt = bit_cnt + 1'b1;
					nxt     = (bit_cnt >= BITS_PER_BYTE) ? PH_FINISH : PH_WRSDA;
				end
				PH_RDLO: begin
					drive_q = 1'b0;
					scl_q   = 1'b0;
					nxt     = PH_RDHI;
				end
				PH_RDHI: begin
					scl_q = 1'b1;
					nxt   = PH_RDSMP;
				end
				PH_RDSMP: begin
					shift_byte = {shift_byte[BYTE_W-2:0], t.sda_in};
					bit_cnt    = bit_cnt + 1'b1;
					if (bit_cnt >= BITS_PER_BYTE) begin
						rd_data = shift_byte;
						nxt     = PH_AKLO;
					end else begin
						nxt = PH_RDLO;
					end
				end
				PH_AKLO: begin
					scl_q = 1'b0;
					nxt   = PH_AKSDA;
				end
				PH_AKSDA: begin
					drive_q = 1'b1;
					sda_q   = !ack_drive;
					nxt     = PH_AKHI;
				end
				PH_AKHI: begin
					scl_q = 1'b1;
					nxt   = PH_AKLO2;
				end
				PH_AKLO2: scl_q = 1'b0;
				default: begin
					// Closing tick: no pin change, pulse done.
					nxt  = PH_IDLE;
					done = 1'b1;
				end
			endcase
			seq_phase = nxt;
			// A zero hold behaves as a hold of one tick.
			hold_cnt = (nxt == PH_IDLE || hold_cfg == '0) ? '0 : hold_cfg - 1'b1;
		end

		r.scl_level  = scl_q;
		r.sda_level  = sda_q;
		r.sda_drive  = drive_q;
		r.busy_res   = (seq_phase != PH_IDLE);
		r.done_res   = done;
		r.read_data  = rd_data;
		r.ack_failed = fail_flag;
		return r;
	endfunction

	function automatic int unsigned draw_wait(input int unsigned pct);
		return ($urandom_range(0, 99) < pct) ? $urandom_range(0, 14) : 0;
	endfunction

	// Random tick; low_pct is the chance that SDA reads low, valid_pct the
	// chance that a (possibly ignored) command is presented.
	function automatic tick_t noise_tick(input int unsigned low_pct, input int unsigned valid_pct);
		tick_t t;
		t.cmd_valid  = ($urandom_range(0, 99) < valid_pct);
		t.command    = 3'($urandom_range(0, CMD_CODE_MAX));
		t.write_byte = 8'($urandom);
		t.send_ack   = 1'($urandom);
		t.sda_in     = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
		return t;
	endfunction

	// Send one tick transaction; keep valid high afterwards so that a
	// back-to-back tick needs no second assignment in the same step.
	task automatic send_tick(input tick_t t);
		int unsigned gap;
		gap = draw_wait(gap_pct);
		if (gap != 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid   <= 1'b1;
		tick_ch.payload <= t;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		expected_levels.push_back(next_bus_levels(t));
	endtask

	// Drop valid before any pause in the tick stream.
	task automatic park_tick();
		tick_ch.valid <= 1'b0;
	endtask

	// Present one command while idle, then tick it through to its done pulse.
	task automatic issue_command(input cmd_t op, input logic [BYTE_W-1:0] data,
			input logic ack, input int unsigned low_pct, input int unsigned busy_pct);
		tick_t t;
		t            = noise_tick(low_pct, 0);
		t.cmd_valid  = 1'b1;
		t.command    = op;
		t.write_byte = data;
		t.send_ack   = ack;
		send_tick(t);
		while (seq_phase != PH_IDLE) send_tick(noise_tick(low_pct, busy_pct));
		command_count++;
	endtask

	// Write a register once the bus is idle and every result has been seen.
	task automatic set_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		park_tick();
		while (expected_levels.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HOLD_TICKS) begin
			hold_cfg = value[HOLD_W-1:0];
		end else begin
			polls_cfg = value[POLL_W-1:0];
		end
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_levels.size() == 0) begin
				$error("result transaction with no expectation pending");
				error_count++;
			end else begin
				want = expected_levels.pop_front();
				check_field("scl_level", want.scl_level, res_ch.payload.scl_level);
				check_field("sda_level", want.sda_level, res_ch.payload.sda_level);
				check_field("sda_drive", want.sda_drive, res_ch.payload.sda_drive);
				check_field("busy_res", want.busy_res, res_ch.payload.busy_res);
				check_field("done_res", want.done_res, res_ch.payload.done_res);
				check_field("read_data", want.read_data, res_ch.payload.read_data);
				check_field("ack_failed", want.ack_failed, res_ch.payload.ack_failed);
			end
		end
	end

	// Stall the result side: draw a wait per result, then hold ready until taken.
	initial begin : result_sink
		int unsigned stall;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(stall_pct);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
		end
	end

	// Bound the run in case the block stops answering.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_i2c_master_byte_sequencer: done, errors");
			$finish;
		end
	end

	// Walk every command but stop at the reset hold, with reads of all-ones and
	// all-zeros bytes, then shorten the hold and time out a wait at the
	// reset poll limit.
	task automatic test_default_config();
		issue_command(CMD_START, '0, 1'b0, 50, 50);
		issue_command(CMD_WRITE, 8'hFF, 1'b1, 50, 50);
		issue_command(CMD_WACK, '0, 1'b0, 30, 50);
		issue_command(CMD_READ, '0, 1'b1, 0, 50);
		issue_command(CMD_READ, '0, 1'b0, 100, 50);
		issue_command(CMD_WACK, '0, 1'b0, 100, 50);
		set_register(CFG_HOLD_TICKS, 10'd1);
		issue_command(CMD_WACK, '0, 1'b0, 0, 50);
	endtask

	// Present illegal codes and no-valid ticks while idle, then keep a command
	// valid on every busy tick, the done tick included.
	task automatic test_ignored_commands();
		tick_t t;
		for (int code = 0; code <= CMD_CODE_MAX; code++) begin
			t           = noise_tick(50, 0);
			t.command   = 3'(code);
			t.cmd_valid = (code > CMD_READ);
			send_tick(t);
		end
		issue_command(CMD_START, '0, 1'b0, 50, 100);
		issue_command(CMD_WRITE, 8'hA5, 1'b0, 50, 100);
		issue_command(CMD_STOP, '0, 1'b1, 50, 100);
	endtask

	// Zero hold acts as one tick; zero timeout fails on the first high poll.
	task automatic test_zero_settings();
		set_register(CFG_HOLD_TICKS, '0);
		set_register(CFG_ACK_POLLS, '0);
		issue_command(CMD_START, '0, 1'b0, 50, 50);
		issue_command(CMD_WACK, '0, 1'b0, 0, 50);
		issue_command(CMD_WACK, '0, 1'b0, 100, 50);
		issue_command(CMD_WRITE, 8'h5A, 1'b0, 50, 50);
		issue_command(CMD_READ, '0, 1'b1, 50, 50);
		issue_command(CMD_STOP, '0, 1'b0, 50, 50);
	endtask

	// Run the largest timeout to exhaustion, written with upper data bits set
	// that must be dropped.
	task automatic test_timeout_limits();
		set_register(CFG_HOLD_TICKS, 10'd1);
		set_register(CFG_ACK_POLLS, 10'h3FF);
		issue_command(CMD_WACK, '0, 1'b0, 0, 50);
	endtask

	// Hold each level for a long time; no idling keeps the run short.
	task automatic test_long_hold();
		gap_pct   = 0;
		stall_pct = 0;
		set_register(CFG_HOLD_TICKS, 10'd20);
		set_register(CFG_ACK_POLLS, 10'd3);
		issue_command(CMD_START, '0, 1'b0, 50, 30);
		issue_command(CMD_STOP, '0, 1'b0, 50, 30);
	endtask

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 8;
			default: return 35;
		endcase
	endfunction

	// Chance of SDA low during a wait: sometimes never, so the wait times out.
	function automatic int unsigned pick_ack_low_pct();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2, 3: return 20;
			default: return 70;
		endcase
	endfunction

	// One bus transaction: start, address, then reads or writes, usually a stop.
	task automatic random_transaction();
		logic [BYTE_W-1:0] addr;
		int unsigned       count;
		addr  = 8'($urandom);
		count = $urandom_range(1, 3);
		issue_command(CMD_START, 8'($urandom), 1'($urandom), 50, 50);
		issue_command(CMD_WRITE, addr, 1'($urandom), 50, 50);
		issue_command(CMD_WACK, 8'($urandom), 1'($urandom), pick_ack_low_pct(), 50);
		for (int unsigned i = 0; i < count; i++) begin
			if (addr[0]) begin
				// ACK every byte but the last, which gets a NACK.
				issue_command(CMD_READ, 8'($urandom), (i != count - 1), 50, 50);
			end else begin
				issue_command(CMD_WRITE, 8'($urandom), 1'($urandom), 50, 50);
				issue_command(CMD_WACK, 8'($urandom), 1'($urandom),
					pick_ack_low_pct(), 50);
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			issue_command(CMD_STOP, 8'($urandom), 1'($urandom), 50, 50);
		end
	endtask

	// Random traffic over several register settings, mostly short holds.
	task automatic test_random_traffic();
		logic [CFG_DATA_W-1:0] hold;
		logic [CFG_DATA_W-1:0] polls;
		int unsigned           target;
		tick_t                 t;
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0: hold = '0;
				1, 2, 3, 4, 5, 6: hold = 10'($urandom_range(1, 2));
				7, 8: hold = 10'($urandom_range(3, 4));
				default: hold = 10'($urandom_range(5, 8));
			endcase
			case ($urandom_range(0, 3))
				0: polls = 10'($urandom_range(0, 3));
				1, 2: polls = 10'($urandom_range(4, 12));
				default: polls = 10'($urandom_range(13, 30));
			endcase
			set_register(CFG_HOLD_TICKS, hold);
			set_register(CFG_ACK_POLLS, polls);
			gap_pct   = pick_idle_pct();
			stall_pct = pick_idle_pct();
			target    = command_count + COMMANDS_PER_PHASE;
			while (command_count < target) begin
				case ($urandom_range(0, 9))
					7: begin
						issue_command(cmd_t'($urandom_range(0, CMD_READ)), 8'($urandom),
							1'($urandom), 50, 50);
					end
					8: begin
						// Idle noise: no valid, or an illegal code.
						repeat ($urandom_range(1, 4)) begin
							t = noise_tick(50, 0);
							if ($urandom_range(0, 1)) begin
								t.cmd_valid = 1'b1;
								t.command   = 3'($urandom_range(CMD_READ + 1, CMD_CODE_MAX));
							end
							send_tick(t);
						end
					end
					9: issue_command(CMD_WACK, 8'($urandom), 1'($urandom), 0, 50);
					default: random_transaction();
				endcase
			end
		end
	endtask

	initial begin
		tick_ch.valid   <= 1'b0;
		tick_ch.payload <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_HOLD_TICKS;
		cfg_wdata       <= '0;
		arst_n          <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_config();
		test_ignored_commands();
		test_zero_settings();
		test_timeout_limits();
		test_long_hold();
		test_random_traffic();

		// Drain: wait for every expected result, then watch for strays.
		park_tick();
		while (expected_levels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_i2c_master_byte_sequencer: done, clean");
		end else begin
			$display("tb_i2c_master_byte_sequencer: done, errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/i2cm_pkg.sv
sv/i2cm_if.sv
sv/i2c_master_byte_sequencer.sv
tb/tb_i2c_master_byte_sequencer.sv
